### src/pivot_matrix_vector_transform_defines.svh
// Assertion macros shared by the pivot matrix-vector transform RTL.
// No dependencies; include from module bodies that need them.
`ifndef PIVOT_MATRIX_VECTOR_TRANSFORM_DEFINES_SVH
`define PIVOT_MATRIX_VECTOR_TRANSFORM_DEFINES_SVH

// Same-cycle implication, checked on every rising clock outside reset.
`define PMVT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pmvt assertion failed");

// Next-cycle implication, checked on every rising clock outside reset.
`define PMVT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pmvt assertion failed");

`endif

### src/pmvt_pkg.sv
// Package for the pivot matrix-vector transform: widths, types, register indexes.
// Used by pmvt_lane, pmvt_merge and pivot_matrix_vector_transform.
`timescale 1ns / 1ps
`default_nettype none

package pmvt_pkg;

   localparam int DATA_WIDTH     = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int LANES          = 3;

   localparam int DIFF_W  = DATA_WIDTH + 1;
   localparam int PROD_W  = DATA_WIDTH + DIFF_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int RND_W   = SUM_W - COEF_FRAC_BITS;
   localparam int VEC_W   = LANES * DATA_WIDTH;
   localparam int ADDR_W  = 3;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic signed [RND_W-1:0]      rnd_type;

   typedef data_type [LANES-1:0] vec_type;
   typedef diff_type [LANES-1:0] diff_vec_type;
   typedef prod_type [LANES-1:0] prod_vec_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam sum_type  ROUND_HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);

   // Reset matrix swaps x and y: 1.0 in row 0 col 1, row 1 col 0, row 2 col 2.
   localparam logic [VEC_W-1:0] ROW0_RESET = VEC_W'(1) << (COEF_FRAC_BITS + DATA_WIDTH);
   localparam logic [VEC_W-1:0] ROW1_RESET = VEC_W'(1) << COEF_FRAC_BITS;
   localparam logic [VEC_W-1:0] ROW2_RESET = VEC_W'(1) << (COEF_FRAC_BITS + 2 * DATA_WIDTH);

   typedef enum logic [ADDR_W-1:0] {
      REG_ROW0      = 3'd0,
      REG_ROW1      = 3'd1,
      REG_ROW2      = 3'd2,
      REG_PIVOT     = 3'd3,
      REG_PIVOT_EN  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic prod_en;
      logic sum_en;
      logic sat_en;
   } lane_ctrl_type;

   typedef struct packed {
      logic valid;
      logic last;
   } merge_ctrl_type;

endpackage

`default_nettype wire

### src/pmvt_lane.sv
// One matrix row lane: three products, exact sum plus pivot term, round and saturate.
// Depends on pmvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmvt_lane (
   input  wire logic                    clock,
   input  wire pmvt_pkg::lane_ctrl_type ctrl,
   input  wire pmvt_pkg::vec_type       coef,
   input  wire pmvt_pkg::diff_vec_type  diff,
   input  wire pmvt_pkg::data_type      pivot,
   output pmvt_pkg::data_type           result,
   output logic                         clip
);
   import pmvt_pkg::*;

   prod_vec_type prod_ff, prod_in;
   sum_type      sum_ff, sum_in;
   data_type     result_ff, result_in;
   logic         clip_ff, clip_in;
   sum_type      rounded;
   rnd_type      shifted;

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         prod_in[c] = $signed(coef[c]) * $signed(diff[c]);
      end
   end

   // Pivot term f * 2^frac enters the sum before rounding.
   always_comb begin
      sum_in = (SUM_W'(pivot) <<< COEF_FRAC_BITS);
      for (int c = 0; c < LANES; c++) begin
         sum_in = sum_in + SUM_W'(prod_ff[c]);
      end
   end

   always_comb begin
      rounded = sum_ff + ROUND_HALF;
      shifted = RND_W'(rounded >>> COEF_FRAC_BITS);
      if (shifted > RND_W'(DATA_MAX)) begin
         result_in = DATA_MAX;
         clip_in   = 1'b1;
      end else if (shifted < RND_W'(DATA_MIN)) begin
         result_in = DATA_MIN;
         clip_in   = 1'b1;
      end else begin
         result_in = shifted[DATA_WIDTH-1:0];
         clip_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.sum_en) begin
         sum_ff <= sum_in;
      end
      if (ctrl.sat_en) begin
         result_ff <= result_in;
         clip_ff   <= clip_in;
      end
   end

   assign result = result_ff;
   assign clip   = clip_ff;

endmodule

`default_nettype wire

### src/pmvt_merge.sv
// Output stage: gathers the lane results into one transfer and ORs the clip flags.
// Depends on pmvt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module pmvt_merge (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pmvt_pkg::merge_ctrl_type     ctrl,
   input  wire pmvt_pkg::vec_type            lane_result,
   input  wire logic [pmvt_pkg::LANES-1:0]   lane_clip,
   output logic                              take,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [pmvt_pkg::VEC_W-1:0]        rsp_tdata,   // out_x, out_y, out_z
   output logic                              rsp_tuser,   // clipped
   output logic                              rsp_tlast
);
   import pmvt_pkg::*;

   `include "pivot_matrix_vector_transform_defines.svh"

   logic    valid_ff, valid_in;
   vec_type data_ff;
   logic    clip_ff;
   logic    last_ff;
   logic    at_bound;

   // Load whenever the register is empty or its transfer completes now.
   assign take     = !valid_ff || rsp_tready;
   assign valid_in = take ? ctrl.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= lane_result;
         clip_ff <= |lane_clip;
         last_ff <= ctrl.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = clip_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      at_bound = 1'b0;
      for (int c = 0; c < LANES; c++) begin
         if ((data_ff[c] == DATA_MAX) || (data_ff[c] == DATA_MIN)) begin
            at_bound = 1'b1;
         end
      end
   end

   `PMVT_ASSERT_NOW(a_clip_at_bound, valid_ff && clip_ff, at_bound)
   `PMVT_ASSERT_NEXT(a_load_shows, ctrl.valid && take, valid_ff)
   `PMVT_ASSERT_NEXT(a_drain_empties, !ctrl.valid && valid_ff && rsp_tready, !valid_ff)

endmodule

`default_nettype wire

### src/pivot_matrix_vector_transform.sv
// Top level of the pivot matrix-vector transform: config registers, difference stage,
// stage valids and the three row lanes. Depends on pmvt_pkg, pmvt_lane, pmvt_merge.
//
// Transforms one signed 3-vector per clock unless the result side stalls:
// out = T*(v - f) + f with Q2.14 coefficients, rounded to nearest (ties up) and
// saturated to 16 bits, or plain T*v when pivot mode is off. Every stage holds
// one vector, so a new vector is taken each cycle while results drain; the
// registered stages from input transfer to result valid are difference, three
// lanes of 16x17 multiply, lane sum, round and saturate, and the output register.
// A stall on the result side backs up stage by stage, and bubbles are squeezed
// out. Write the registers only with no vector in flight.
`timescale 1ns / 1ps
`default_nettype none

module pivot_matrix_vector_transform (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [pmvt_pkg::VEC_W-1:0]          req_tdata,   // vec_x, vec_y, vec_z
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [pmvt_pkg::VEC_W-1:0]               rsp_tdata,   // out_x, out_y, out_z
   output logic                                     rsp_tuser,   // clipped
   output logic                                     rsp_tlast,
   input  wire logic                                csr_wen,
   input  wire logic [pmvt_pkg::ADDR_W-1:0]         csr_addr,
   input  wire logic [pmvt_pkg::VEC_W-1:0]          csr_wdata
);
   import pmvt_pkg::*;

   `include "pivot_matrix_vector_transform_defines.svh"

   localparam int STAGES = 4;

   vec_type        row_ff [LANES];
   vec_type        pivot_ff;
   logic           pivot_en_ff;

   vec_type        vec_in;
   vec_type        pivot_sel;
   diff_vec_type   diff_ff, diff_in;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] last_ff;
   logic [STAGES:0]   en;
   logic              take;

   vec_type           lane_result;
   logic [LANES-1:0]  lane_clip;
   lane_ctrl_type     lane_ctrl;
   merge_ctrl_type    merge_ctrl;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]   <= ROW0_RESET;
         row_ff[1]   <= ROW1_RESET;
         row_ff[2]   <= ROW2_RESET;
         pivot_ff    <= '0;
         pivot_en_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_addr)
            REG_ROW0:     row_ff[0]   <= csr_wdata;
            REG_ROW1:     row_ff[1]   <= csr_wdata;
            REG_ROW2:     row_ff[2]   <= csr_wdata;
            REG_PIVOT:    pivot_ff    <= csr_wdata;
            REG_PIVOT_EN: pivot_en_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Pivot point drops out entirely when pivot mode is off.
   assign pivot_sel = pivot_en_ff ? pivot_ff : '0;
   assign vec_in    = req_tdata;

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         diff_in[c] = DIFF_W'(vec_in[c]) - DIFF_W'(pivot_sel[c]);
      end
   end

   // A stage advances when it is empty or the stage after it advances.
   always_comb begin
      en[STAGES] = take;
      for (int k = STAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[0];

   always_comb begin
      valid_in[0] = en[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         diff_ff    <= diff_in;
         last_ff[0] <= req_tlast;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (en[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   assign lane_ctrl.prod_en = en[1];
   assign lane_ctrl.sum_en  = en[2];
   assign lane_ctrl.sat_en  = en[3];

   for (genvar r = 0; r < LANES; r++) begin : g_lane
      pmvt_lane u_lane (
         .clock  (clock),
         .ctrl   (lane_ctrl),
         .coef   (row_ff[r]),
         .diff   (diff_ff),
         .pivot  (pivot_sel[r]),
         .result (lane_result[r]),
         .clip   (lane_clip[r])
      );
   end

   assign merge_ctrl.valid = valid_ff[STAGES-1];
   assign merge_ctrl.last  = last_ff[STAGES-1];

   pmvt_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (merge_ctrl),
      .lane_result (lane_result),
      .lane_clip   (lane_clip),
      .take        (take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   `PMVT_ASSERT_NEXT(a_accept_enters, req_tvalid && req_tready, valid_ff[0])
   `PMVT_ASSERT_NOW(a_empty_ready, (valid_ff == '0), req_tready)
   `PMVT_ASSERT_NEXT(a_stall_holds, valid_ff[STAGES-1] && !take, valid_ff[STAGES-1])

endmodule

`default_nettype wire
